@@ rtl/core/siie_pkg.sv @@
// Shared types and constants for the instruction executor.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package siie_pkg;
   typedef struct packed {
      logic        req_type;
      logic [31:0] instr_word;
      logic [31:0] preload_address;
      logic signed [31:0] preload_value;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_write_en;
      logic [4:0]  reg_write_index;
      logic signed [31:0] reg_write_value;
      logic        mem_write_en;
      logic [31:0] mem_write_address;
      logic signed [31:0] mem_write_value;
      logic [1:0]  error_code;
   } rsp_beat_type;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] a;
      logic [31:0] b;
   } md_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_res_type;

   localparam logic [31:0] RESET_START = 32'd256;
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UNDEF = 2'd1;
   localparam logic [1:0] ERR_DIV0 = 2'd2;

   localparam logic [2:0] CAT_CTRL = 3'd0;
   localparam logic [2:0] CAT_ALU = 3'd1;
   localparam logic [2:0] CAT_IMM = 3'd2;
   localparam logic [2:0] CAT_MD = 3'd3;
   localparam logic [2:0] CAT_MOVE = 3'd4;

   localparam logic [2:0] OP_J = 3'd0;
   localparam logic [2:0] OP_BEQ = 3'd1;
   localparam logic [2:0] OP_BNE = 3'd2;
   localparam logic [2:0] OP_BGTZ = 3'd3;
   localparam logic [2:0] OP_SW = 3'd4;
   localparam logic [2:0] OP_LW = 3'd5;
   localparam logic [2:0] OP_BREAK = 3'd6;
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_AND = 3'd2;
   localparam logic [2:0] OP_OR = 3'd3;
   localparam logic [2:0] OP_SRL = 3'd4;
   localparam logic [2:0] OP_SRA = 3'd5;
   localparam logic [2:0] OP_ADDI = 3'd0;
   localparam logic [2:0] OP_ANDI = 3'd1;
   localparam logic [2:0] OP_ORI = 3'd2;
   localparam logic [2:0] OP_MULT = 3'd0;
   localparam logic [2:0] OP_DIV = 3'd1;
   localparam logic [2:0] OP_MFHI = 3'd0;
   localparam logic [2:0] OP_MFLO = 3'd1;
endpackage
`default_nettype wire

@@ rtl/core/subset_isa_instruction_executor.sv @@
// Top level of the instruction executor: sequencer, register file, data memory.
// Depends on siie_pkg and siie_muldiv.
//
// Usage: one request beat carries either an instruction to run at the current
// PC (req_type 0) or a data word to preload (req_type 1). Every request beat
// yields exactly one response beat describing what changed.
// Timing: a beat is read in state S_READ, then executed in S_EXEC; register
// and memory reads are registered. Plain instructions then go straight to the
// response state; MULT, and DIV with a nonzero divisor, run on the shared
// one-bit-per-cycle multiply/divide unit first. One beat is in flight at a
// time; req_stall is high until the response is taken.
// Reset: the register file and data memory are swept to zero, one entry per
// cycle; requests stall meanwhile, CSR writes are taken. A write to
// start_address also loads the PC.
// A stalled response holds its payload until rsp_stall drops.
`timescale 1ns / 1ps
`default_nettype none
module subset_isa_instruction_executor #(
   parameter int DATA_WORDS = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire siie_pkg::req_beat_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output siie_pkg::rsp_beat_type     rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [1:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import siie_pkg::*;

   localparam int AW = $clog2(DATA_WORDS);
   localparam int CW = (AW > 5) ? AW : 5;
   localparam logic [CW:0] CLR_LAST = (DATA_WORDS > 32) ? (CW+1)'(DATA_WORDS - 1)
                                                        : (CW+1)'(31);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_MD = 3'd4;
   localparam logic [2:0] S_RSP = 3'd5;

   logic [31:0] regs [32];
   logic [31:0] dmem [DATA_WORDS];

   logic [2:0]  state_ff, state_in;
   logic [CW:0] clr_ff;
   logic [31:0] start_ff, pc_ff, hi_ff, lo_ff;
   logic        stop_ff;
   req_beat_type rq_ff;
   logic [31:0] ra_ff, rb_ff, rc_ff, md_ff;
   rsp_beat_type out_ff, ex;
   md_cmd_type  md_cmd;
   md_res_type  md_res;

   logic [2:0]  cat, op;
   logic [4:0]  rs, rt, rd;
   logic [31:0] simm, npc4, btgt;
   logic        csr_wr, accept;

   assign cat = rq_ff.instr_word[31:29];
   assign op  = rq_ff.instr_word[28:26];
   assign rs  = rq_ff.instr_word[25:21];
   assign rt  = rq_ff.instr_word[20:16];
   assign rd  = rq_ff.instr_word[15:11];
   assign simm = {{16{rq_ff.instr_word[15]}}, rq_ff.instr_word[15:0]};
   assign npc4 = pc_ff + 32'd4;
   assign btgt = npc4 + {simm[29:0], 2'b00};
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? start_ff : 32'd0;
   assign accept = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data = out_ff;

   always_comb begin
      ex = '0;
      ex.next_pc = npc4;
      ex.halted = stop_ff;
      if (rq_ff.req_type) begin
         ex.next_pc = pc_ff;
         ex.mem_write_en = 1'b1;
         ex.mem_write_address = rq_ff.preload_address;
         ex.mem_write_value = rq_ff.preload_value;
      end else if (stop_ff) begin
         ex.next_pc = pc_ff;
      end else begin
         case (cat)
            CAT_CTRL: begin
               case (op)
                  OP_J: ex.next_pc = {npc4[31:28], rq_ff.instr_word[25:0], 2'b00};
                  OP_BEQ: if (ra_ff == rb_ff) ex.next_pc = btgt;
                  OP_BNE: if (ra_ff != rb_ff) ex.next_pc = btgt;
                  OP_BGTZ: if (ra_ff != 32'd0 && !ra_ff[31]) ex.next_pc = btgt;
                  OP_SW: begin
                     ex.mem_write_en = 1'b1;
                     ex.mem_write_address = ra_ff + simm;
                     ex.mem_write_value = rb_ff;
                  end
                  OP_LW: begin
                     ex.reg_write_en = 1'b1;
                     ex.reg_write_index = rt;
                     ex.reg_write_value = md_ff;
                  end
                  OP_BREAK: ex.halted = 1'b1;
                  default: ex.error_code = ERR_UNDEF;
               endcase
            end
            CAT_ALU: begin
               ex.reg_write_en = 1'b1;
               ex.reg_write_index = rs;
               case (op)
                  OP_ADD: ex.reg_write_value = rb_ff + rc_ff;
                  OP_SUB: ex.reg_write_value = rb_ff - rc_ff;
                  OP_AND: ex.reg_write_value = rb_ff & rc_ff;
                  OP_OR: ex.reg_write_value = rb_ff | rc_ff;
                  OP_SRL: ex.reg_write_value = rb_ff >> rd;
                  OP_SRA: ex.reg_write_value = $signed(rb_ff) >>> rd;
                  default: begin
                     ex.reg_write_en = 1'b0;
                     ex.reg_write_index = 5'd0;
                     ex.error_code = ERR_UNDEF;
                  end
               endcase
            end
            CAT_IMM: begin
               ex.reg_write_en = 1'b1;
               ex.reg_write_index = rs;
               case (op)
                  OP_ADDI: ex.reg_write_value = rb_ff + simm;
                  OP_ANDI: ex.reg_write_value = rb_ff & simm;
                  OP_ORI: ex.reg_write_value = rb_ff | simm;
                  default: begin
                     ex.reg_write_en = 1'b0;
                     ex.reg_write_index = 5'd0;
                     ex.error_code = ERR_UNDEF;
                  end
               endcase
            end
            CAT_MD: begin
               if (op == OP_DIV) begin
                  if (rb_ff == 32'd0) ex.error_code = ERR_DIV0;
               end else if (op != OP_MULT) begin
                  ex.error_code = ERR_UNDEF;
               end
            end
            CAT_MOVE: begin
               if (op == OP_MFHI || op == OP_MFLO) begin
                  ex.reg_write_en = 1'b1;
                  ex.reg_write_index = rs;
                  ex.reg_write_value = (op == OP_MFHI) ? hi_ff : lo_ff;
               end else begin
                  ex.error_code = ERR_UNDEF;
               end
            end
            default: ex.error_code = ERR_UNDEF;
         endcase
      end
   end

   always_comb begin
      md_cmd.start = 1'b0;
      md_cmd.is_div = (op == OP_DIV);
      md_cmd.a = ra_ff;
      md_cmd.b = rb_ff;
      if (state_ff == S_EXEC && !rq_ff.req_type && !stop_ff && cat == CAT_MD &&
          (op == OP_MULT || (op == OP_DIV && rb_ff != 32'd0))) begin
         md_cmd.start = 1'b1;
      end
   end

   siie_muldiv u_md (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .res   (md_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == CLR_LAST) state_in = S_IDLE;
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = md_cmd.start ? S_MD : S_RSP;
         S_MD: if (md_res.done) state_in = S_RSP;
         S_RSP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         start_ff <= RESET_START;
         pc_ff <= RESET_START;
         hi_ff <= 32'd0;
         lo_ff <= 32'd0;
         stop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_wr && csr_paddr == 2'd0) begin
            start_ff <= csr_pwdata;
            pc_ff <= csr_pwdata;
         end
         if (state_ff == S_EXEC) begin
            pc_ff <= ex.next_pc;
            stop_ff <= ex.halted;
         end
         if (state_ff == S_MD && md_res.done) begin
            hi_ff <= md_res.hi;
            lo_ff <= md_res.lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rq_ff <= req_data;
      if (state_ff == S_READ) begin
         ra_ff <= regs[rs];
         rb_ff <= regs[rt];
         rc_ff <= regs[rd];
         md_ff <= dmem[AW'((regs[rs] + simm) >> 2)];
      end
      if (state_ff == S_EXEC) out_ff <= ex;
      if (state_ff == S_CLEAR) begin
         if (clr_ff < (CW+1)'(32)) regs[clr_ff[4:0]] <= 32'd0;
         if (clr_ff < (CW+1)'(DATA_WORDS)) dmem[clr_ff[AW-1:0]] <= 32'd0;
      end else if (state_ff == S_EXEC) begin
         if (ex.reg_write_en) regs[ex.reg_write_index] <= ex.reg_write_value;
         if (ex.mem_write_en) dmem[AW'(ex.mem_write_address >> 2)] <= ex.mem_write_value;
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/siie_muldiv.sv @@
// Iterative signed multiply and divide unit, one bit per cycle.
// Depends on siie_pkg for the command and result structs.
`timescale 1ns / 1ps
`default_nettype none
module siie_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire siie_pkg::md_cmd_type cmd,
   output siie_pkg::md_res_type     res
);
   import siie_pkg::*;

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic [5:0]  count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] m_ff, m_in;
   logic        nq_ff, nq_in;
   logic        nr_ff, nr_in;
   logic        done_ff, done_in;
   logic [31:0] mag_a, mag_b, diff_lo;
   logic [32:0] sum, trial;
   logic [63:0] prod, prod_neg;
   logic [31:0] quo, rem;

   assign mag_a = cmd.a[31] ? (~cmd.a + 32'd1) : cmd.a;
   assign mag_b = cmd.b[31] ? (~cmd.b + 32'd1) : cmd.b;
   assign sum   = {1'b0, acc_ff} + {1'b0, (q_ff[0] ? m_ff : 32'd0)};
   assign trial = {acc_ff, q_ff[31]} - {1'b0, m_ff};
   assign diff_lo = 32'd0;
   assign prod  = {acc_ff, q_ff};
   assign prod_neg = ~prod + 64'd1;
   assign quo = nq_ff ? (~q_ff + 32'd1) : q_ff;
   assign rem = nr_ff ? (~acc_ff + 32'd1) : acc_ff;

   always_comb begin
      busy_in = busy_ff;
      div_in = div_ff;
      count_in = count_ff;
      acc_in = acc_ff;
      q_in = q_ff;
      m_in = m_ff;
      nq_in = nq_ff;
      nr_in = nr_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in = cmd.is_div;
         count_in = 6'd0;
         acc_in = diff_lo;
         q_in = mag_a;
         m_in = mag_b;
         nq_in = cmd.a[31] ^ cmd.b[31];
         nr_in = cmd.a[31];
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!trial[32]) begin
               acc_in = trial[31:0];
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               acc_in = {acc_ff[30:0], q_ff[31]};
               q_in = {q_ff[30:0], 1'b0};
            end
         end else begin
            acc_in = sum[32:1];
            q_in = {sum[0], q_ff[31:1]};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      count_ff <= count_in;
      acc_ff <= acc_in;
      q_ff <= q_in;
      m_ff <= m_in;
      nq_ff <= nq_in;
      nr_ff <= nr_in;
   end

   always_comb begin
      res.done = done_ff;
      if (div_ff) begin
         res.hi = rem;
         res.lo = quo;
      end else if (nq_ff) begin
         res.hi = prod_neg[63:32];
         res.lo = prod_neg[31:0];
      end else begin
         res.hi = prod[63:32];
         res.lo = prod[31:0];
      end
   end
endmodule
`default_nettype wire

@@ tb/tb_subset_isa_instruction_executor.sv @@
// Self-checking testbench for subset_isa_instruction_executor: directed and random
// instruction streams are checked beat by beat against an in-bench executor model.
// Depends on siie_pkg and the RTL of the executor only.
`timescale 1ns / 1ps
module tb_subset_isa_instruction_executor;
   import siie_pkg::*;

   localparam int MEM_WORDS = 256;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 45;
   localparam int HOLD_CYCLES = 300;
   localparam logic [1:0] ADDR_START = 2'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_beat_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   subset_isa_instruction_executor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [31:0] pc_model;
   logic [31:0] regs_model [32];
   logic [31:0] hi_model, lo_model;
   logic [31:0] mem_model [MEM_WORDS];
   logic halted_model;
   rsp_beat_type expected_beats [$];
   int errors = 0;
   int idle_max = 18;
   int rsp_wait = 0;
   int quiet_cycles = 0;
   logic hold_on = 1'b0;
   event hold_kick;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_beat_type execute_model(req_beat_type r);
      rsp_beat_type o;
      logic [31:0] ins, a, b, c, simm, addr;
      logic [2:0] cat, op;
      logic [4:0] rs, rt, rd;
      longint x, y;
      logic [63:0] p;
      o = '0;
      ins = r.instr_word;
      cat = ins[31:29];
      op = ins[28:26];
      rs = ins[25:21];
      rt = ins[20:16];
      rd = ins[15:11];
      simm = {{16{ins[15]}}, ins[15:0]};
      a = regs_model[rs];
      b = regs_model[rt];
      c = regs_model[rd];
      o.next_pc = pc_model + 32'd4;
      if (r.req_type) begin
         o.mem_write_en = 1'b1;
         o.mem_write_address = r.preload_address;
         o.mem_write_value = r.preload_value;
         mem_model[r.preload_address[9:2]] = r.preload_value;
         o.next_pc = pc_model;
      end else if (halted_model) begin
         o.next_pc = pc_model;
      end else begin
         case (cat)
            CAT_CTRL: begin
               case (op)
                  OP_J: o.next_pc = {o.next_pc[31:28], ins[25:0], 2'b00};
                  OP_BEQ: if (a == b) o.next_pc = pc_model + 32'd4 + (simm << 2);
                  OP_BNE: if (a != b) o.next_pc = pc_model + 32'd4 + (simm << 2);
                  OP_BGTZ: if (a != 0 && !a[31]) o.next_pc = pc_model + 32'd4 + (simm << 2);
                  OP_SW: begin
                     addr = a + simm;
                     o.mem_write_en = 1'b1;
                     o.mem_write_address = addr;
                     o.mem_write_value = b;
                     mem_model[addr[9:2]] = b;
                  end
                  OP_LW: begin
                     addr = a + simm;
                     o.reg_write_en = 1'b1;
                     o.reg_write_index = rt;
                     o.reg_write_value = mem_model[addr[9:2]];
                  end
                  OP_BREAK: halted_model = 1'b1;
                  default: o.error_code = ERR_UNDEF;
               endcase
            end
            CAT_ALU: begin
               o.reg_write_en = 1'b1;
               o.reg_write_index = rs;
               case (op)
                  OP_ADD: o.reg_write_value = b + c;
                  OP_SUB: o.reg_write_value = b - c;
                  OP_AND: o.reg_write_value = b & c;
                  OP_OR: o.reg_write_value = b | c;
                  OP_SRL: o.reg_write_value = b >> rd;
                  OP_SRA: o.reg_write_value = $signed(b) >>> rd;
                  default: begin
                     o.reg_write_en = 1'b0;
                     o.reg_write_index = '0;
                     o.error_code = ERR_UNDEF;
                  end
               endcase
            end
            CAT_IMM: begin
               o.reg_write_en = 1'b1;
               o.reg_write_index = rs;
               case (op)
                  OP_ADDI: o.reg_write_value = b + simm;
                  OP_ANDI: o.reg_write_value = b & simm;
                  OP_ORI: o.reg_write_value = b | simm;
                  default: begin
                     o.reg_write_en = 1'b0;
                     o.reg_write_index = '0;
                     o.error_code = ERR_UNDEF;
                  end
               endcase
            end
            CAT_MD: begin
               x = longint'($signed(a));
               y = longint'($signed(b));
               if (op == OP_MULT) begin
                  p = x * y;
                  hi_model = p[63:32];
                  lo_model = p[31:0];
               end else if (op == OP_DIV) begin
                  if (y == 0) begin
                     o.error_code = ERR_DIV0;
                  end else begin
                     p = x / y;
                     lo_model = p[31:0];
                     p = x % y;
                     hi_model = p[31:0];
                  end
               end else begin
                  o.error_code = ERR_UNDEF;
               end
            end
            CAT_MOVE: begin
               if (op == OP_MFHI || op == OP_MFLO) begin
                  o.reg_write_en = 1'b1;
                  o.reg_write_index = rs;
                  o.reg_write_value = (op == OP_MFHI) ? hi_model : lo_model;
               end else begin
                  o.error_code = ERR_UNDEF;
               end
            end
            default: o.error_code = ERR_UNDEF;
         endcase
      end
      if (o.reg_write_en) regs_model[o.reg_write_index] = o.reg_write_value;
      pc_model = o.next_pc;
      o.halted = halted_model;
      return o;
   endfunction

   task automatic send_beat(req_beat_type r);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_beats.insert(expected_beats.size(), execute_model(r));
   endtask

   task automatic run_instr(logic [31:0] w);
      req_beat_type r;
      r.req_type = 1'b0;
      r.instr_word = w;
      r.preload_address = $urandom();
      r.preload_value = $urandom();
      send_beat(r);
   endtask

   task automatic preload_word(logic [31:0] addr, logic [31:0] value);
      req_beat_type r;
      r.req_type = 1'b1;
      r.instr_word = $urandom();
      r.preload_address = addr;
      r.preload_value = value;
      send_beat(r);
   endtask

   function automatic logic [31:0] enc_r(logic [2:0] cat, logic [2:0] op,
                                         logic [4:0] rs, logic [4:0] rt, logic [4:0] rd);
      return {cat, op, rs, rt, rd, 11'd0};
   endfunction

   function automatic logic [31:0] enc_i(logic [2:0] cat, logic [2:0] op,
                                         logic [4:0] rs, logic [4:0] rt, logic [15:0] imm);
      return {cat, op, rs, rt, imm};
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_address(logic [31:0] value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_START;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      pc_model = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $display("%0t start_address readback: expected %h actual %h", $time, value, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [31:0] random_instr();
      logic [2:0] cat, op;
      logic [31:0] w;
      w = $urandom();
      cat = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      op = 3'($urandom());
      if (cat == CAT_CTRL && op == OP_BREAK) op = OP_LW;
      return {cat, op, w[25:0]};
   endfunction

   task automatic test_preload_and_load();
      preload_word(32'h0000_0400, 32'h8000_0000);
      preload_word(32'hFFFF_FFFF, 32'h7FFF_FFFF);
      run_instr(enc_i(CAT_CTRL, OP_LW, 5'd0, 5'd1, 16'd0));
      run_instr(enc_i(CAT_CTRL, OP_LW, 5'd0, 5'd2, 16'hFFFC));
   endtask

   task automatic test_alu_and_immediate();
      run_instr(enc_i(CAT_IMM, OP_ADDI, 5'd3, 5'd0, 16'h7FFF));
      run_instr(enc_i(CAT_IMM, OP_ADDI, 5'd4, 5'd0, 16'h8000));
      run_instr(enc_r(CAT_ALU, OP_ADD, 5'd5, 5'd1, 5'd4));
      run_instr(enc_r(CAT_ALU, OP_SUB, 5'd6, 5'd1, 5'd3));
      run_instr(enc_r(CAT_ALU, OP_AND, 5'd7, 5'd2, 5'd4));
      run_instr(enc_r(CAT_ALU, OP_OR, 5'd8, 5'd2, 5'd1));
      run_instr(enc_r(CAT_ALU, OP_SRL, 5'd9, 5'd4, 5'd31));
      run_instr(enc_r(CAT_ALU, OP_SRA, 5'd10, 5'd4, 5'd4));
      run_instr(enc_i(CAT_IMM, OP_ANDI, 5'd11, 5'd2, 16'h8001));
      run_instr(enc_i(CAT_IMM, OP_ORI, 5'd12, 5'd3, 16'hFFFF));
   endtask

   task automatic test_branch_and_store();
      run_instr(enc_i(CAT_CTRL, OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
      run_instr(enc_i(CAT_CTRL, OP_BNE, 5'd1, 5'd2, 16'h7FFF));
      run_instr(enc_i(CAT_CTRL, OP_BGTZ, 5'd3, 5'd0, 16'h8000));
      run_instr(enc_i(CAT_CTRL, OP_BGTZ, 5'd4, 5'd0, 16'h0004));
      run_instr({CAT_CTRL, OP_J, 26'h3FF_FFFF});
      run_instr(enc_i(CAT_CTRL, OP_SW, 5'd3, 5'd2, 16'h8000));
   endtask

   task automatic test_mul_div();
      run_instr(enc_i(CAT_IMM, OP_ADDI, 5'd13, 5'd0, 16'hFFFF));
      run_instr(enc_r(CAT_MD, OP_MULT, 5'd1, 5'd1, 5'd0));
      run_instr(enc_r(CAT_MOVE, OP_MFHI, 5'd14, 5'd0, 5'd0));
      run_instr(enc_r(CAT_MD, OP_DIV, 5'd1, 5'd13, 5'd0));
      run_instr(enc_r(CAT_MD, OP_DIV, 5'd1, 5'd0, 5'd0));
      run_instr(enc_r(CAT_MOVE, OP_MFLO, 5'd15, 5'd0, 5'd0));
      run_instr(enc_r(CAT_MOVE, OP_MFHI, 5'd16, 5'd0, 5'd0));
   endtask

   task automatic test_undefined();
      run_instr({3'd7, 3'd7, 26'h3FF_FFFF});
      run_instr({CAT_CTRL, 3'd7, 26'd0});
      run_instr({CAT_ALU, 3'd6, 26'h155_5555});
      run_instr({CAT_IMM, 3'd3, 26'd0});
      run_instr({CAT_MD, 3'd2, 26'd0});
      run_instr({CAT_MOVE, 3'd7, 26'd0});
      run_instr({3'd5, 3'd0, 26'd0});
   endtask

   task automatic test_start_address();
      write_start_address(32'hFFFF_FFFC);
      run_instr(enc_r(CAT_ALU, OP_ADD, 5'd17, 5'd1, 5'd2));
      run_instr(enc_i(CAT_CTRL, OP_BEQ, 5'd0, 5'd0, 16'hFFFE));
      write_start_address(32'h0000_0000);
      run_instr(enc_i(CAT_CTRL, OP_BNE, 5'd1, 5'd0, 16'hFFFF));
      write_start_address(32'hFFFF_FFFF);
      run_instr(enc_i(CAT_IMM, OP_ADDI, 5'd18, 5'd1, 16'd1));
   endtask

   task automatic test_backpressure();
      idle_max = 0;
      -> hold_kick;
      repeat (12) run_instr(random_instr());
      wait_drained();
      idle_max = 18;
   endtask

   task automatic test_random_stream(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 6) == 0)
            preload_word($urandom(), $urandom());
         else
            run_instr(random_instr());
      end
   endtask

   task automatic test_halt();
      run_instr({CAT_CTRL, OP_BREAK, 26'h2AA_AAAA});
      run_instr(enc_r(CAT_ALU, OP_ADD, 5'd19, 5'd1, 5'd1));
      preload_word(32'h0000_0010, 32'hDEAD_BEEF);
      run_instr({CAT_CTRL, OP_BREAK, 26'd0});
      run_instr(enc_i(CAT_CTRL, OP_LW, 5'd0, 5'd20, 16'h0010));
   endtask

   task automatic report_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type e;
      if (rsp_valid && !rsp_stall) begin
         rsp_wait = $urandom_range(0, idle_max);
         if (expected_beats.size() == 0) begin
            $display("%0t unexpected result beat: expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            report_field("next_pc", e.next_pc, rsp_data.next_pc);
            report_field("halted", e.halted, rsp_data.halted);
            report_field("reg_write_en", e.reg_write_en, rsp_data.reg_write_en);
            report_field("reg_write_index", e.reg_write_index, rsp_data.reg_write_index);
            report_field("reg_write_value", e.reg_write_value, rsp_data.reg_write_value);
            report_field("mem_write_en", e.mem_write_en, rsp_data.mem_write_en);
            report_field("mem_write_address", e.mem_write_address,
                         rsp_data.mem_write_address);
            report_field("mem_write_value", e.mem_write_value, rsp_data.mem_write_value);
            report_field("error_code", e.error_code, rsp_data.error_code);
         end
      end
      if (hold_on) begin
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      forever begin
         @(hold_kick);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      pc_model = RESET_START;
      foreach (regs_model[i]) regs_model[i] = '0;
      foreach (mem_model[i]) mem_model[i] = '0;
      hi_model = '0;
      lo_model = '0;
      halted_model = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_preload_and_load();
      test_alu_and_immediate();
      test_branch_and_store();
      test_mul_div();
      test_undefined();
      test_start_address();
      test_backpressure();
      test_random_stream(600);
      write_start_address($urandom());
      idle_max = 0;
      test_random_stream(400);
      write_start_address(32'h0000_0100);
      idle_max = 18;
      test_random_stream(500);
      write_start_address($urandom());
      idle_max = 4;
      test_random_stream(400);
      idle_max = 18;
      test_halt();
      wait_drained();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
